[hw/rtl/lba_region_to_chs_track_chunks_unit_defines.svh]
// Assertion macros shared by the track chunk splitter RTL.
`ifndef LBA_REGION_TO_CHS_TRACK_CHUNKS_UNIT_DEFINES_SVH
`define LBA_REGION_TO_CHS_TRACK_CHUNKS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LRC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrc assertion failed");

// Next-cycle implication, checked outside reset.
`define LRC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrc assertion failed");

`endif

[hw/rtl/lrc_pkg.sv]
// Types, constants and codes shared by the track chunk splitter.
package lrc_pkg;

    localparam int unsigned LBA_W      = 16;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned SPT_W      = 6;
    localparam int unsigned HEADS_W    = 8;
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned CYL_W      = 8;
    localparam int unsigned TRACK_W    = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    // Serial divider operand widths.
    localparam int unsigned DVD_W = 16;
    localparam int unsigned DVS_W = 8;

    // Bytes moved per sector; the offset advances by this much per sector.
    localparam int unsigned SECTOR_BYTES = 512;

    localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd9;
    localparam logic [SPT_W-1:0]   SPT_MIN     = 6'd8;
    localparam logic [HEADS_W-1:0] HEADS_RESET = 8'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 1'b1;

    typedef struct packed {
        logic [LBA_W-1:0]  start_lba;
        logic [CNT_W-1:0]  sector_count;
        logic [ADDR_W-1:0] buffer_segment;
        logic [ADDR_W-1:0] buffer_offset;
    } lrc_in_t;

    typedef struct packed {
        logic [CYL_W-1:0]   cylinder;
        logic [HEADS_W-1:0] head;
        logic [SPT_W-1:0]   sector;
        logic [SPT_W-1:0]   chunk_sectors;
        logic [ADDR_W-1:0]  segment;
        logic [ADDR_W-1:0]  offset;
        logic               cylinder_overflow;
        logic               last;
    } lrc_out_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } lrc_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } lrc_div_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_SPT,
        ST_DIV_HEAD,
        ST_EMIT
    } lrc_state_t;

endpackage

[hw/rtl/lba_region_to_chs_track_chunks_unit.sv]
// Top level: splits a disk transfer request into track-bounded CHS chunks.
//
// A request (start LBA, sector count, buffer segment and offset) enters on the
// s_ channel; one result per track-bounded chunk leaves on the m_ channel, the
// final one marked by last. A request with a zero count gives no results.
// Geometry comes from two registers written through cfg_we/cfg_index/cfg_wdata
// (index 0 sectors per track, index 1 heads); the user must write them only
// while no request is in flight, which the block itself does not enforce.
// The start LBA is divided by sectors per track and the quotient then by heads
// in one serial divider, each division ending in a done pulse. After the second,
// the sequencer enters its emit state and loads the output register once it
// is free. Further chunks leave back to back while the receiver keeps m_ready
// high; only an LBA that wraps past 65535 sends the sequencer through both
// divisions again before the next chunk.
// One request is worked at a time; s_ready is high while the sequencer idles,
// even if the last result still waits in the output register.
// A receiver stall holds the output register and pauses chunk generation.
// Reset clears the sequencer and the output valid and loads the geometry
// registers with 9 sectors per track and 2 heads.
`include "lba_region_to_chs_track_chunks_unit_defines.svh"

module lba_region_to_chs_track_chunks_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lrc_pkg::lrc_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lrc_pkg::lrc_out_t                  m_data,
    input  logic                               cfg_we,
    input  logic [lrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    lrc_pkg::lrc_state_t state_reg;
    lrc_pkg::lrc_state_t state_next;

    logic [lrc_pkg::SPT_W-1:0]   spt_reg;
    logic [lrc_pkg::HEADS_W-1:0] heads_reg;

    logic [lrc_pkg::LBA_W-1:0]   lba_reg;
    logic [lrc_pkg::CNT_W-1:0]   remain_reg;
    logic [lrc_pkg::ADDR_W-1:0]  seg_reg;
    logic [lrc_pkg::ADDR_W-1:0]  ofs_reg;
    logic [lrc_pkg::SPT_W-1:0]   sec0_reg;
    logic [lrc_pkg::HEADS_W-1:0] head_reg;
    logic [lrc_pkg::TRACK_W-1:0] cyl_reg;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    lrc_pkg::lrc_out_t           m_data_reg;

    lrc_pkg::lrc_div_req_t       div_req;
    lrc_pkg::lrc_div_rsp_t       div_rsp;

    logic [lrc_pkg::SPT_W-1:0]   spt_eff;
    logic [lrc_pkg::HEADS_W-1:0] heads_eff;
    logic [lrc_pkg::SPT_W-1:0]   span;
    logic [lrc_pkg::SPT_W-1:0]   chunk_n;
    logic [lrc_pkg::CNT_W-1:0]   remain_left;
    logic [lrc_pkg::LBA_W:0]     lba_sum;
    logic [lrc_pkg::HEADS_W-1:0] head_inc;
    logic                        head_wrap;
    logic [lrc_pkg::ADDR_W-1:0]  ofs_step;
    logic                        out_free;
    logic                        load_out;
    logic                        in_take;
    logic                        div_wait;
    logic                        in_emit;

    // Geometry registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg   <= lrc_pkg::SPT_RESET;
            heads_reg <= lrc_pkg::HEADS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lrc_pkg::CFG_SPT:   spt_reg   <= cfg_wdata[lrc_pkg::SPT_W-1:0];
                lrc_pkg::CFG_HEADS: heads_reg <= cfg_wdata[lrc_pkg::HEADS_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range geometry is clamped to usable values.
    assign spt_eff   = (spt_reg < lrc_pkg::SPT_MIN) ? lrc_pkg::SPT_MIN : spt_reg;
    assign heads_eff = (heads_reg == '0) ? lrc_pkg::HEADS_W'(1) : heads_reg;

    // Chunk length runs to the end of the track or the end of the request.
    always_comb begin
        span        = spt_eff - sec0_reg;
        chunk_n     = ({2'b00, span} > remain_reg) ? remain_reg[lrc_pkg::SPT_W-1:0] : span;
        remain_left = remain_reg - {2'b00, chunk_n};
        lba_sum     = {1'b0, lba_reg} + (lrc_pkg::LBA_W + 1)'(chunk_n);
        head_inc    = head_reg + 1'b1;
        head_wrap   = (head_inc == heads_eff);
        ofs_step    = lrc_pkg::ADDR_W'(32'(chunk_n) * lrc_pkg::SECTOR_BYTES);
        out_free    = !m_valid_reg || m_ready;
    end

    lrc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer: next state, divider starts and output loads.
    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = s_data.start_lba;
        div_req.divisor  = {2'b00, spt_eff};
        unique case (state_reg)
            lrc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_data.sector_count != '0)) begin
                    div_req.start = 1'b1;
                    state_next    = lrc_pkg::ST_DIV_SPT;
                end
            end
            lrc_pkg::ST_DIV_SPT: begin
                div_req.dividend = div_rsp.quotient;
                div_req.divisor  = heads_eff;
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    state_next    = lrc_pkg::ST_DIV_HEAD;
                end
            end
            lrc_pkg::ST_DIV_HEAD: begin
                if (div_rsp.done) begin
                    state_next = lrc_pkg::ST_EMIT;
                end
            end
            lrc_pkg::ST_EMIT: begin
                div_req.dividend = lba_sum[lrc_pkg::LBA_W-1:0];
                if (out_free) begin
                    load_out = 1'b1;
                    if (remain_left == '0) begin
                        state_next = lrc_pkg::ST_IDLE;
                    end else if (lba_sum[lrc_pkg::LBA_W]) begin
                        // The LBA wrapped, so the next chunk needs a fresh conversion.
                        div_req.start = 1'b1;
                        state_next    = lrc_pkg::ST_DIV_SPT;
                    end
                end
            end
            default: state_next = lrc_pkg::ST_IDLE;
        endcase
    end

    assign in_take      = s_valid && s_ready;
    assign m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lrc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request and chunk-position registers.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            lba_reg    <= s_data.start_lba;
            remain_reg <= s_data.sector_count;
            seg_reg    <= s_data.buffer_segment;
            ofs_reg    <= s_data.buffer_offset;
        end
        if ((state_reg == lrc_pkg::ST_DIV_SPT) && div_rsp.done) begin
            sec0_reg <= div_rsp.remainder[lrc_pkg::SPT_W-1:0];
        end
        if ((state_reg == lrc_pkg::ST_DIV_HEAD) && div_rsp.done) begin
            head_reg <= div_rsp.remainder;
            cyl_reg  <= div_rsp.quotient;
        end
        if (load_out) begin
            // The next chunk starts on the first sector of the following track.
            remain_reg <= remain_left;
            lba_reg    <= lba_sum[lrc_pkg::LBA_W-1:0];
            ofs_reg    <= ofs_reg + ofs_step;
            sec0_reg   <= '0;
            head_reg   <= head_wrap ? '0 : head_inc;
            cyl_reg    <= head_wrap ? (cyl_reg + 1'b1) : cyl_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg.cylinder          <= cyl_reg[lrc_pkg::CYL_W-1:0];
            m_data_reg.head              <= head_reg;
            m_data_reg.sector            <= sec0_reg + 1'b1;
            m_data_reg.chunk_sectors     <= chunk_n;
            m_data_reg.segment           <= seg_reg;
            m_data_reg.offset            <= ofs_reg;
            m_data_reg.cylinder_overflow <= |cyl_reg[lrc_pkg::TRACK_W-1:lrc_pkg::CYL_W];
            m_data_reg.last              <= (remain_left == '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer phases watched by the checks below.
    assign div_wait = (state_reg == lrc_pkg::ST_DIV_SPT) || (state_reg == lrc_pkg::ST_DIV_HEAD);
    assign in_emit  = (state_reg == lrc_pkg::ST_EMIT);

    // A chunk emitted with room in the output register shows up as valid.
    `LRC_ASSERT_NEXT(a_emit_loads, aclk, aresetn, load_out, m_valid_reg)
    // Every chunk carries at least one sector.
    `LRC_ASSERT_NOW(a_chunk_nonzero, aclk, aresetn, m_valid_reg, m_data_reg.chunk_sectors != '0)
    // The divider only finishes while the sequencer waits for it.
    `LRC_ASSERT_NOW(a_div_owner, aclk, aresetn, div_rsp.done, div_wait)
    // The tracked head stays below the head count while chunks are emitted.
    `LRC_ASSERT_NOW(a_head_range, aclk, aresetn, in_emit, head_reg < heads_eff)

endmodule

[hw/rtl/lrc_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module lrc_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lrc_pkg::lrc_div_req_t req,
    output lrc_pkg::lrc_div_rsp_t rsp
);

    localparam int unsigned STEP_W = $clog2(lrc_pkg::DVD_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [lrc_pkg::DVD_W-1:0] quo_reg;
    logic [lrc_pkg::DVS_W-1:0] rem_reg;
    logic [lrc_pkg::DVS_W-1:0] dvs_reg;

    logic [lrc_pkg::DVS_W:0]   trial;
    logic [lrc_pkg::DVS_W:0]   diff;
    logic                      fits;
    logic [lrc_pkg::DVS_W-1:0] rem_next;
    logic [lrc_pkg::DVD_W-1:0] quo_next;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
        trial    = {rem_reg, quo_reg[lrc_pkg::DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[lrc_pkg::DVS_W-1:0] : trial[lrc_pkg::DVS_W-1:0];
        quo_next = {quo_reg[lrc_pkg::DVD_W-2:0], fits};
    end

    // Control: busy flag, step counter and the done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(lrc_pkg::DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[tb/lba_region_to_chs_track_chunks_unit_test.sv]
// Testbench for the track chunk splitter: directed and random requests, checked by a predictor.
module lba_region_to_chs_track_chunks_unit_test;

    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned SETTLE_CYCLES  = 48;
    localparam int unsigned PHASE_REQUESTS = 40;
    localparam int unsigned OPENING_RANDOM = 20;
    localparam int unsigned PHASES         = 7;
    localparam int unsigned RANDOM_PHASE   = 5;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } ready_mode_t;

    // Predicts the chunks of each accepted request and checks the chunks that come out.
    class chs_chunk_board;
        logic [lrc_pkg::SPT_W-1:0]   spt_reg;
        logic [lrc_pkg::HEADS_W-1:0] heads_reg;
        lrc_pkg::lrc_out_t           expected_chunks[$];
        int unsigned                 failures;

        function new();
            spt_reg   = lrc_pkg::SPT_RESET;
            heads_reg = lrc_pkg::HEADS_RESET;
            failures  = 0;
        endfunction

        function void set_geometry(input logic [lrc_pkg::SPT_W-1:0] spt,
                                   input logic [lrc_pkg::HEADS_W-1:0] heads);
            spt_reg   = spt;
            heads_reg = heads;
        endfunction

        function int unsigned pending();
            return expected_chunks.size();
        endfunction

        // Walk the request track by track, one chunk per track touched.
        function void note_request(input lrc_pkg::lrc_in_t req);
            int unsigned       lba;
            int unsigned       left;
            int unsigned       ofs;
            int unsigned       spt;
            int unsigned       heads;
            int unsigned       track;
            int unsigned       sec0;
            int unsigned       cyl;
            int unsigned       n;
            lrc_pkg::lrc_out_t chunk;
            lba   = 32'(req.start_lba);
            left  = 32'(req.sector_count);
            ofs   = 32'(req.buffer_offset);
            // Degenerate geometry is clamped rather than divided by.
            spt   = (spt_reg < lrc_pkg::SPT_MIN) ? 32'(lrc_pkg::SPT_MIN) : 32'(spt_reg);
            heads = (heads_reg == 0) ? 1 : 32'(heads_reg);
            while (left > 0) begin
                track = lba / spt;
                sec0  = lba % spt;
                cyl   = track / heads;
                n     = spt - sec0;
                if (n > left) begin
                    n = left;
                end
                left = left - n;
                chunk.cylinder          = cyl[lrc_pkg::CYL_W-1:0];
                chunk.head              = 8'(track % heads);
                chunk.sector            = 6'(sec0 + 1);
                chunk.chunk_sectors     = n[lrc_pkg::SPT_W-1:0];
                chunk.segment           = req.buffer_segment;
                chunk.offset            = ofs[lrc_pkg::ADDR_W-1:0];
                chunk.cylinder_overflow = (cyl > 255);
                chunk.last              = (left == 0);
                expected_chunks.push_back(chunk);
                // LBA and offset both wrap at 16 bits.
                lba = (lba + n) & 16'hFFFF;
                ofs = (ofs + n * lrc_pkg::SECTOR_BYTES) & 16'hFFFF;
            end
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_chunk(input lrc_pkg::lrc_out_t got);
            lrc_pkg::lrc_out_t want;
            if (expected_chunks.size() == 0) begin
                $error("chunk with no request waiting: cylinder %0d head %0d sector %0d",
                       got.cylinder, got.head, got.sector);
                failures++;
                return;
            end
            want = expected_chunks.pop_front();
            compare_field("cylinder", want.cylinder, got.cylinder);
            compare_field("head", want.head, got.head);
            compare_field("sector", want.sector, got.sector);
            compare_field("chunk_sectors", want.chunk_sectors, got.chunk_sectors);
            compare_field("segment", want.segment, got.segment);
            compare_field("offset", want.offset, got.offset);
            compare_field("cylinder_overflow", want.cylinder_overflow, got.cylinder_overflow);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    lrc_pkg::lrc_in_t               s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    lrc_pkg::lrc_out_t              m_data;
    logic                           cfg_we    = 1'b0;
    logic [lrc_pkg::CFG_IDX_W-1:0]  cfg_index = lrc_pkg::CFG_SPT;
    logic [lrc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    chs_chunk_board board;
    int unsigned    burst_left  = 0;
    bit             valid_held  = 1'b0;
    int unsigned    cycle_count = 0;
    ready_mode_t    ready_mode  = READY_ALWAYS;
    int unsigned    ready_span  = 0;

    // Directed requests, run under the reset geometry of 9 sectors and 2 heads.
    lrc_pkg::lrc_in_t directed_requests [11] = '{
        {16'd0,     8'd1,   16'h0000, 16'h0000},   // single sector at the origin
        {16'd0,     8'd0,   16'h0000, 16'h0000},   // zero count, no chunks
        {16'hFFFF,  8'd255, 16'hFFFF, 16'hFFFF},   // LBA wrap, large cylinder, offset wrap
        {16'd8,     8'd1,   16'h0001, 16'h0200},   // last sector of a track
        {16'd9,     8'd9,   16'h0002, 16'h0000},   // exactly one whole track
        {16'd5,     8'd255, 16'h1000, 16'hFF00},   // many chunks from mid-track
        {16'd4607,  8'd20,  16'h2000, 16'h0000},   // crosses from cylinder 255 to 256
        {16'd65530, 8'd10,  16'h1234, 16'h8000},   // LBA wraps inside the request
        {16'hAAAA,  8'h55,  16'h5555, 16'hAAAA},
        {16'h5555,  8'hAA,  16'hAAAA, 16'h5555},
        {16'd17,    8'd2,   16'h00FF, 16'hFE00}    // runs across a track boundary
    };

    // Geometry per non-random phase; 8'hFF and 8'hC5 also drive unused upper data bits.
    logic [7:0] spt_settings   [PHASES] = '{8'hFF, 8'd8, 8'd0, 8'hC5, 8'd17, 8'd9, 8'd63};
    logic [7:0] heads_settings [PHASES] = '{8'd255, 8'd1, 8'd0, 8'd128, 8'd16, 8'd2, 8'd1};

    lba_region_to_chs_track_chunks_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver readiness follows a randomly chosen mode that is held for a random span.
    always @(posedge aclk) begin
        if (ready_span == 0) begin
            ready_mode = ready_mode_t'($urandom_range(READY_ALWAYS, READY_SPARSE));
            ready_span = $urandom_range(20, 150);
        end else begin
            ready_span = ready_span - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            default:      m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check every chunk the receiver takes.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_chunk(m_data);
        end
    end

    function automatic lrc_pkg::lrc_in_t make_request();
        lrc_pkg::lrc_in_t req;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        req.start_lba = (pick < 15) ? 16'(65535 - $urandom_range(0, 300)) : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            req.sector_count = 8'd0;
        end else if (pick < 14) begin
            req.sector_count = 8'($urandom_range(200, 255));
        end else if (pick < 50) begin
            req.sector_count = 8'($urandom_range(1, 20));
        end else begin
            req.sector_count = 8'($urandom_range(1, 120));
        end
        req.buffer_segment = 16'($urandom);
        req.buffer_offset  = 16'($urandom);
        return req;
    endfunction

    // Hold the request until the block takes it.
    task automatic send_request(input lrc_pkg::lrc_in_t req);
        s_valid    <= 1'b1;
        s_data     <= req;
        valid_held = 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        board.note_request(req);
    endtask

    task automatic lower_valid();
        if (valid_held) begin
            s_valid    <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Bursts of requests with random gaps; now and then wait for every chunk.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            lower_valid();
            @(posedge aclk);
            if ($urandom_range(0, 29) == 0) begin
                wait_drained();
            end else begin
                repeat ($urandom_range(0, ($urandom_range(0, 7) == 0) ? 40 : 8)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // Only called with nothing in flight.
    task automatic write_geometry(input logic [7:0] spt_value, input logic [7:0] heads_value);
        cfg_we    <= 1'b1;
        cfg_index <= lrc_pkg::CFG_SPT;
        cfg_wdata <= spt_value;
        @(posedge aclk);
        cfg_index <= lrc_pkg::CFG_HEADS;
        cfg_wdata <= heads_value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.set_geometry(spt_value[lrc_pkg::SPT_W-1:0], heads_value);
    endtask

    task automatic settle_idle();
        lower_valid();
        @(posedge aclk);
        wait_drained();
        // Leave a quiet margin before the geometry changes.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        lrc_pkg::lrc_in_t req;
        int unsigned      phase;
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(1, 8);

        // Reset geometry: directed requests, then a few random ones.
        foreach (directed_requests[k]) begin
            send_request(directed_requests[k]);
            pace_sender();
        end
        repeat (OPENING_RANDOM) begin
            send_request(make_request());
            pace_sender();
        end

        // Each phase sets a new geometry and opens with a long request.
        for (phase = 0; phase < PHASES; phase++) begin
            settle_idle();
            if (phase == RANDOM_PHASE) begin
                write_geometry(8'($urandom_range(8, 63)), 8'($urandom_range(1, 255)));
            end else begin
                write_geometry(spt_settings[phase], heads_settings[phase]);
            end
            req = make_request();
            req.sector_count = 8'd255;
            send_request(req);
            pace_sender();
            repeat (PHASE_REQUESTS) begin
                send_request(make_request());
                pace_sender();
            end
        end

        settle_idle();
        if (board.failures == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
